// ===== rtl/kcpc_pkg.sv =====
`timescale 1ns / 1ps

package kcpc_pkg;

    typedef enum logic [2:0] {
        REQ_US_TICK   = 3'd0,
        REQ_MS_TICK   = 3'd1,
        REQ_KICK      = 3'd2,
        REQ_BOOST_EN  = 3'd3,
        REQ_CLEAR     = 3'd4,
        REQ_PAUSE     = 3'd5,
        REQ_RESUME    = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        CFG_SAMPLE_GAIN      = 3'd0,
        CFG_BOOST_OFF_LEVEL  = 3'd1,
        CFG_BOOST_ON_LEVEL   = 3'd2,
        CFG_DISCHARGE_LEVEL  = 3'd3,
        CFG_SAMPLE_PERIOD_MS = 3'd4,
        CFG_CLEAR_PERIOD_MS  = 3'd5,
        CFG_CLEAR_PULSE_US   = 3'd6,
        CFG_CLEAR_LIMIT      = 3'd7
    } t_cfg_idx;

    localparam logic [15:0] RST_SAMPLE_GAIN      = 16'd2928;
    localparam logic [15:0] RST_BOOST_OFF_LEVEL  = 16'd2560;
    localparam logic [15:0] RST_BOOST_ON_LEVEL   = 16'd2240;
    localparam logic [15:0] RST_DISCHARGE_LEVEL  = 16'd384;
    localparam logic [7:0]  RST_SAMPLE_PERIOD_MS = 8'd5;
    localparam logic [7:0]  RST_CLEAR_PERIOD_MS  = 8'd10;
    localparam logic [15:0] RST_CLEAR_PULSE_US   = 16'd150;
    localparam logic [9:0]  RST_CLEAR_LIMIT      = 10'd500;

    localparam logic [31:0] KICK_MAX      = 32'd65000;
    localparam int          VOLT_SHIFT    = 12;
    localparam logic [7:0]  MS_SAT        = 8'hFF;
    localparam logic [9:0]  CLEAR_CNT_SAT = 10'h3FF;

endpackage

// ===== rtl/kicker_charge_and_pulse_controller.sv =====
`timescale 1ns / 1ps

// channel  | valid        | ready        | payload
// ---------+--------------+--------------+---------------------------------------------
// input    | i_in_valid   | o_in_ready   | i_req_type i_adc_sample i_kicker_select
//          |              |              | i_kick_power i_boost_enable
// output   | o_out_valid  | i_out_ready  | o_boost_drive o_coil1_fire o_coil2_fire
//          |              |              | o_cap_level o_charge_enabled o_clear_active
//          |              |              | o_pulse_active
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index i_cfg_data
//
// one transaction per cycle sustained while the output is not stalled
// stage 1 registers the request and the adc times gain product, stage 2 updates
// the controller state, which is itself the result register
// synchronous active-low reset restores the register defaults and the power-up state
// a stalled result holds stage 1; input ready drops only when both stages are full
// config port always ready

module kicker_charge_and_pulse_controller #(
    parameter int ADC_BITS   = 12,
    parameter int PULSE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_req_type,
    input  logic [ADC_BITS-1:0] i_adc_sample,
    input  logic                i_kicker_select,
    input  logic signed [16:0]  i_kick_power,
    input  logic                i_boost_enable,

    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_boost_drive,
    output logic                o_coil1_fire,
    output logic                o_coil2_fire,
    output logic [15:0]         o_cap_level,
    output logic                o_charge_enabled,
    output logic                o_clear_active,
    output logic                o_pulse_active,

    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int          PROD_BITS = ADC_BITS + 16;
    localparam logic [31:0] PULSE_MAX = 32'((64'd1 << PULSE_BITS) - 64'd1);

    function automatic logic [PULSE_BITS-1:0] clamp_width(input logic [15:0] w);
        logic [31:0] v;
        v = {16'd0, w};
        if (v > kcpc_pkg::KICK_MAX) v = kcpc_pkg::KICK_MAX;
        if (v > PULSE_MAX) v = PULSE_MAX;
        return v[PULSE_BITS-1:0];
    endfunction

    // configuration registers
    logic [15:0] r_cfg_sample_gain;
    logic [15:0] r_cfg_boost_off_level;
    logic [15:0] r_cfg_boost_on_level;
    logic [15:0] r_cfg_discharge_level;
    logic [7:0]  r_cfg_sample_period_ms;
    logic [7:0]  r_cfg_clear_period_ms;
    logic [15:0] r_cfg_clear_pulse_us;
    logic [9:0]  r_cfg_clear_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sample_gain      <= kcpc_pkg::RST_SAMPLE_GAIN;
            r_cfg_boost_off_level  <= kcpc_pkg::RST_BOOST_OFF_LEVEL;
            r_cfg_boost_on_level   <= kcpc_pkg::RST_BOOST_ON_LEVEL;
            r_cfg_discharge_level  <= kcpc_pkg::RST_DISCHARGE_LEVEL;
            r_cfg_sample_period_ms <= kcpc_pkg::RST_SAMPLE_PERIOD_MS;
            r_cfg_clear_period_ms  <= kcpc_pkg::RST_CLEAR_PERIOD_MS;
            r_cfg_clear_pulse_us   <= kcpc_pkg::RST_CLEAR_PULSE_US;
            r_cfg_clear_limit      <= kcpc_pkg::RST_CLEAR_LIMIT;
        end else if (i_cfg_valid) begin
            case (kcpc_pkg::t_cfg_idx'(i_cfg_index))
                kcpc_pkg::CFG_SAMPLE_GAIN:      r_cfg_sample_gain      <= i_cfg_data;
                kcpc_pkg::CFG_BOOST_OFF_LEVEL:  r_cfg_boost_off_level  <= i_cfg_data;
                kcpc_pkg::CFG_BOOST_ON_LEVEL:   r_cfg_boost_on_level   <= i_cfg_data;
                kcpc_pkg::CFG_DISCHARGE_LEVEL:  r_cfg_discharge_level  <= i_cfg_data;
                kcpc_pkg::CFG_SAMPLE_PERIOD_MS: r_cfg_sample_period_ms <= i_cfg_data[7:0];
                kcpc_pkg::CFG_CLEAR_PERIOD_MS:  r_cfg_clear_period_ms  <= i_cfg_data[7:0];
                kcpc_pkg::CFG_CLEAR_PULSE_US:   r_cfg_clear_pulse_us   <= i_cfg_data;
                kcpc_pkg::CFG_CLEAR_LIMIT:      r_cfg_clear_limit      <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // stage 1: request register and sample product
    logic                  r_s1_valid;
    kcpc_pkg::t_req        r_s1_req;
    logic                  r_s1_sel;
    logic signed [16:0]    r_s1_kick_power;
    logic                  r_s1_enable;
    logic [PROD_BITS-1:0]  r_s1_prod;
    logic                  r_out_valid;
    logic                  s1_adv;

    assign s1_adv      = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_req        <= kcpc_pkg::t_req'(i_req_type);
            r_s1_sel        <= i_kicker_select;
            r_s1_kick_power <= i_kick_power;
            r_s1_enable     <= i_boost_enable;
            r_s1_prod       <= PROD_BITS'(i_adc_sample) * PROD_BITS'(r_cfg_sample_gain);
        end
    end

    // stage 2: controller state, presented directly as the result
    logic                  r_boost_pin, n_boost_pin;
    logic                  r_coil1_pin, n_coil1_pin;
    logic                  r_coil2_pin, n_coil2_pin;
    logic [PULSE_BITS-1:0] r_pulse_left, n_pulse_left;
    logic                  r_pulse_running, n_pulse_running;
    logic                  r_charge_on, n_charge_on;
    logic                  r_paused, n_paused;
    logic                  r_relaunch, n_relaunch;
    logic                  r_clearing, n_clearing;
    logic [9:0]            r_clear_count, n_clear_count;
    logic [7:0]            r_ms_since_sample, n_ms_since_sample;
    logic [7:0]            r_ms_since_clear, n_ms_since_clear;
    logic                  r_hyst_on, n_hyst_on;
    logic [15:0]           r_filtered, n_filtered;

    logic [31:0]           volt_wide;
    logic [15:0]           volt;
    logic [23:0]           filt_sum;
    logic [PULSE_BITS-1:0] kick_width;
    logic [PULSE_BITS-1:0] clear_width;

    always_comb begin
        volt_wide = 32'(r_s1_prod) >> kcpc_pkg::VOLT_SHIFT;
        volt      = (|volt_wide[31:16]) ? 16'hFFFF : volt_wide[15:0];
        // 253 * v + 3 * f as shift-adds
        filt_sum  = ({8'd0, volt} << 8) - ({8'd0, volt} << 1) - {8'd0, volt}
                  + ({8'd0, r_filtered} << 1) + {8'd0, r_filtered};
        kick_width  = clamp_width(r_s1_kick_power[15:0]);
        clear_width = clamp_width(r_cfg_clear_pulse_us);
    end

    always_comb begin
        n_boost_pin       = r_boost_pin;
        n_coil1_pin       = r_coil1_pin;
        n_coil2_pin       = r_coil2_pin;
        n_pulse_left      = r_pulse_left;
        n_pulse_running   = r_pulse_running;
        n_charge_on       = r_charge_on;
        n_paused          = r_paused;
        n_relaunch        = r_relaunch;
        n_clearing        = r_clearing;
        n_clear_count     = r_clear_count;
        n_ms_since_sample = r_ms_since_sample;
        n_ms_since_clear  = r_ms_since_clear;
        n_hyst_on         = r_hyst_on;
        n_filtered        = r_filtered;

        case (r_s1_req)
            kcpc_pkg::REQ_US_TICK: begin
                if (r_pulse_running) begin
                    if (r_pulse_left <= PULSE_BITS'(1)) begin
                        n_pulse_left    = '0;
                        n_pulse_running = 1'b0;
                        n_coil1_pin     = 1'b0;
                        n_coil2_pin     = 1'b0;
                        n_relaunch      = 1'b1;
                    end else begin
                        n_pulse_left = r_pulse_left - PULSE_BITS'(1);
                    end
                end
            end
            kcpc_pkg::REQ_MS_TICK: begin
                if (r_ms_since_sample != kcpc_pkg::MS_SAT)
                    n_ms_since_sample = r_ms_since_sample + 8'd1;
                if (r_ms_since_clear != kcpc_pkg::MS_SAT)
                    n_ms_since_clear = r_ms_since_clear + 8'd1;

                if (n_ms_since_sample > r_cfg_sample_period_ms) begin
                    if (volt >= r_cfg_boost_off_level && r_hyst_on) begin
                        n_boost_pin = 1'b0;
                        n_hyst_on   = 1'b0;
                    end else if (volt <= r_cfg_boost_on_level && !r_hyst_on) begin
                        n_boost_pin = 1'b1;
                        n_hyst_on   = 1'b1;
                    end
                    n_ms_since_sample = '0;
                    n_filtered        = filt_sum[23:8];
                    if (filt_sum[23:8] > r_cfg_discharge_level && !r_charge_on) begin
                        n_clearing    = 1'b1;
                        n_clear_count = '0;
                    end
                end

                // clearing kick fires both coils
                if (n_clearing && n_ms_since_clear >= r_cfg_clear_period_ms) begin
                    n_ms_since_clear = '0;
                    n_coil1_pin      = 1'b1;
                    n_coil2_pin      = 1'b1;
                    n_pulse_left     = clear_width;
                    n_pulse_running  = 1'b1;
                    if (r_charge_on) n_boost_pin = 1'b0;
                    if (n_clear_count != kcpc_pkg::CLEAR_CNT_SAT)
                        n_clear_count = n_clear_count + 10'd1;
                    if (n_clear_count > r_cfg_clear_limit) n_clearing = 1'b0;
                end

                if (r_relaunch) begin
                    n_relaunch  = 1'b0;
                    n_boost_pin = r_charge_on && !r_paused;
                end
            end
            kcpc_pkg::REQ_KICK: begin
                if (!r_s1_kick_power[16]) begin
                    if (r_s1_sel) n_coil2_pin = 1'b1;
                    else          n_coil1_pin = 1'b1;
                    n_pulse_left    = kick_width;
                    n_pulse_running = 1'b1;
                    if (r_charge_on) n_boost_pin = 1'b0;
                end
            end
            kcpc_pkg::REQ_BOOST_EN: begin
                n_charge_on = r_s1_enable;
                if (r_s1_enable) n_clearing = 1'b0;
                n_relaunch = 1'b1;
            end
            kcpc_pkg::REQ_CLEAR: begin
                n_clearing    = 1'b1;
                n_clear_count = '0;
            end
            kcpc_pkg::REQ_PAUSE: begin
                n_paused = 1'b1;
                if (r_charge_on) n_boost_pin = 1'b0;
            end
            kcpc_pkg::REQ_RESUME: begin
                n_paused = 1'b0;
                if (r_charge_on) n_boost_pin = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boost_pin       <= 1'b0;
            r_coil1_pin       <= 1'b0;
            r_coil2_pin       <= 1'b0;
            r_pulse_left      <= '0;
            r_pulse_running   <= 1'b0;
            r_charge_on       <= 1'b1;
            r_paused          <= 1'b1;
            r_relaunch        <= 1'b1;
            r_clearing        <= 1'b0;
            r_clear_count     <= '0;
            r_ms_since_sample <= '0;
            r_ms_since_clear  <= '0;
            r_hyst_on         <= 1'b0;
            r_filtered        <= '0;
        end else if (s1_adv) begin
            r_boost_pin       <= n_boost_pin;
            r_coil1_pin       <= n_coil1_pin;
            r_coil2_pin       <= n_coil2_pin;
            r_pulse_left      <= n_pulse_left;
            r_pulse_running   <= n_pulse_running;
            r_charge_on       <= n_charge_on;
            r_paused          <= n_paused;
            r_relaunch        <= n_relaunch;
            r_clearing        <= n_clearing;
            r_clear_count     <= n_clear_count;
            r_ms_since_sample <= n_ms_since_sample;
            r_ms_since_clear  <= n_ms_since_clear;
            r_hyst_on         <= n_hyst_on;
            r_filtered        <= n_filtered;
        end
    end

    assign o_boost_drive    = r_boost_pin;
    assign o_coil1_fire     = r_coil1_pin;
    assign o_coil2_fire     = r_coil2_pin;
    assign o_cap_level      = r_filtered;
    assign o_charge_enabled = r_charge_on;
    assign o_clear_active   = r_clearing;
    assign o_pulse_active   = r_pulse_running;

    // a coil only fires while the pulse timer runs
    a_coils_need_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pulse_running |-> (!r_coil1_pin && !r_coil2_pin))
        else $error("coil firing without running pulse");

    a_ready_low_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipe");

    // a waiting result must not change under a stall
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            ($stable(r_filtered) && $stable(r_boost_pin) && $stable(r_clearing)))
        else $error("result changed while stalled");

    a_stage1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(r_s1_prod)))
        else $error("stage 1 lost while stalled");

endmodule
